/* rtl/core/mdml_pkg.sv */
// Shared widths, register map and types for the mecanum drive mixer and limiter.
package mdml_pkg;

    localparam int COMMAND_WIDTH = 16;

    localparam int GAIN_W    = 16;
    localparam int CLAMP_W   = 15;
    localparam int TOT_W     = 18;
    localparam int WORD_W    = 16;
    localparam int LANES     = 4;

    localparam int LIN_W     = COMMAND_WIDTH + 2;
    localparam int KW_W      = COMMAND_WIDTH + GAIN_W + 1;
    localparam int SUM_W     = COMMAND_WIDTH + 18;
    localparam int MAG_W     = 41;
    localparam int EXT_W     = (SUM_W > MAG_W) ? SUM_W : MAG_W;
    localparam int PROD_W    = MAG_W + GAIN_W;

    localparam int Q_W        = CLAMP_W;
    localparam int NUM_W      = CLAMP_W + TOT_W;
    localparam int REM_W      = TOT_W;
    localparam int DIV_BITS   = 3;
    localparam int DIV_STAGES = Q_W / DIV_BITS;

    localparam logic [EXT_W-1:0] MAG_CAP = EXT_W'(1) << (MAG_W - 1);

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [2:0] REG_WHEEL_GAIN    = 3'd0;
    localparam logic [2:0] REG_FRONT_YAW_ARM = 3'd1;
    localparam logic [2:0] REG_BACK_YAW_ARM  = 3'd2;
    localparam logic [2:0] REG_CLAMP_LIMIT   = 3'd3;
    localparam logic [2:0] REG_TOTAL_LIMIT   = 3'd4;

    typedef struct packed {
        logic [GAIN_W-1:0]  wheel_gain;
        logic [GAIN_W-1:0]  front_yaw_arm;
        logic [GAIN_W-1:0]  back_yaw_arm;
        logic [CLAMP_W-1:0] clamp_limit;
        logic [TOT_W-1:0]   total_limit;
    } t_cfg;

    typedef logic [LANES-1:0][CLAMP_W-1:0] t_mag_vec;

endpackage

/* rtl/core/mecanum_drive_mixer_limiter_unit.sv */
// A result strobes on o_valid once the accepted command has passed the mixer, sum, divider and output registers.
// Throughput: one command per cycle, busy is never raised; the divide pipeline
// (five stages of three quotient bits) sets the depth.
// Reset: synchronous active-low i_rst_n clears all valid bits and loads the
// register defaults; the receiver cannot stall, results are never held.
module mecanum_drive_mixer_limiter_unit (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      start,
    output logic                                      busy,
    input  logic signed [mdml_pkg::COMMAND_WIDTH-1:0] i_vx,
    input  logic signed [mdml_pkg::COMMAND_WIDTH-1:0] i_vy,
    input  logic signed [mdml_pkg::COMMAND_WIDTH-1:0] i_wz,
    output logic                                      o_valid,
    output logic signed [mdml_pkg::WORD_W-1:0]        o_wheel_rf,
    output logic signed [mdml_pkg::WORD_W-1:0]        o_wheel_lf,
    output logic signed [mdml_pkg::WORD_W-1:0]        o_wheel_lb,
    output logic signed [mdml_pkg::WORD_W-1:0]        o_wheel_rb,
    output logic                                      o_power_limited,
    input  logic                                      psel,
    input  logic                                      penable,
    input  logic                                      pwrite,
    input  logic [mdml_pkg::ADDR_W-1:0]               paddr,
    input  logic [mdml_pkg::DATA_W-1:0]               pwdata,
    output logic [mdml_pkg::DATA_W-1:0]               prdata,
    output logic                                      pready
);
    import mdml_pkg::*;

    t_cfg                          r_cfg;
    logic                          mix_valid;
    logic [LANES-1:0]              mix_neg;
    t_mag_vec                      mix_mag;
    logic [LANES-1:0][WORD_W-1:0]  wheel;

    assign busy   = 1'b0;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wheel_gain    <= GAIN_W'(256);
            r_cfg.front_yaw_arm <= GAIN_W'(256);
            r_cfg.back_yaw_arm  <= GAIN_W'(256);
            r_cfg.clamp_limit   <= CLAMP_W'(16384);
            r_cfg.total_limit   <= TOT_W'(131072);
        end else if (psel && penable && pwrite) begin
            unique case (paddr[4:2])
                REG_WHEEL_GAIN:    r_cfg.wheel_gain    <= pwdata[GAIN_W-1:0];
                REG_FRONT_YAW_ARM: r_cfg.front_yaw_arm <= pwdata[GAIN_W-1:0];
                REG_BACK_YAW_ARM:  r_cfg.back_yaw_arm  <= pwdata[GAIN_W-1:0];
                REG_CLAMP_LIMIT:   r_cfg.clamp_limit   <= pwdata[CLAMP_W-1:0];
                REG_TOTAL_LIMIT:   r_cfg.total_limit   <= pwdata[TOT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_WHEEL_GAIN:    prdata = DATA_W'(r_cfg.wheel_gain);
            REG_FRONT_YAW_ARM: prdata = DATA_W'(r_cfg.front_yaw_arm);
            REG_BACK_YAW_ARM:  prdata = DATA_W'(r_cfg.back_yaw_arm);
            REG_CLAMP_LIMIT:   prdata = DATA_W'(r_cfg.clamp_limit);
            REG_TOTAL_LIMIT:   prdata = DATA_W'(r_cfg.total_limit);
            default:           prdata = '0;
        endcase
    end

    mdml_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_vx    (i_vx),
        .i_vy    (i_vy),
        .i_wz    (i_wz),
        .i_cfg   (r_cfg),
        .o_valid (mix_valid),
        .o_neg   (mix_neg),
        .o_mag   (mix_mag)
    );

    mdml_limit u_limit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (mix_valid),
        .i_neg       (mix_neg),
        .i_mag       (mix_mag),
        .i_max_total (r_cfg.total_limit),
        .o_valid     (o_valid),
        .o_wheel     (wheel),
        .o_flag      (o_power_limited)
    );

    assign o_wheel_rf = wheel[0];
    assign o_wheel_lf = wheel[1];
    assign o_wheel_lb = wheel[2];
    assign o_wheel_rb = wheel[3];

endmodule

/* rtl/core/mdml_mix.sv */
// Three-stage inverse kinematics: yaw products, signed sum and magnitude, gain multiply and per-wheel clamp.
module mdml_mix (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    input  logic signed [mdml_pkg::COMMAND_WIDTH-1:0] i_vx,
    input  logic signed [mdml_pkg::COMMAND_WIDTH-1:0] i_vy,
    input  logic signed [mdml_pkg::COMMAND_WIDTH-1:0] i_wz,
    input  mdml_pkg::t_cfg                           i_cfg,
    output logic                                     o_valid,
    output logic [mdml_pkg::LANES-1:0]               o_neg,
    output mdml_pkg::t_mag_vec                       o_mag
);
    import mdml_pkg::*;

    logic                                  r_v1, r_v2, r_v3;
    logic signed [LANES-1:0][LIN_W-1:0]    r_lin, n_lin;
    logic signed [KW_W-1:0]                r_kwf, r_kwb, n_kwf, n_kwb;
    logic [LANES-1:0][MAG_W-1:0]           r_mag2, n_mag2;
    logic [LANES-1:0]                      r_neg2, n_neg2, r_neg3;
    t_mag_vec                              r_mag3, n_mag3;

    // stage 1: linear terms and yaw lever products
    always_comb begin
        logic signed [LIN_W-1:0] vx_e, vy_e;
        vx_e = $signed({{2{i_vx[COMMAND_WIDTH-1]}}, i_vx});
        vy_e = $signed({{2{i_vy[COMMAND_WIDTH-1]}}, i_vy});
        n_lin[0] = -vx_e + vy_e;
        n_lin[1] =  vx_e + vy_e;
        n_lin[2] =  vx_e - vy_e;
        n_lin[3] = -vx_e - vy_e;
        n_kwf = $signed({1'b0, i_cfg.front_yaw_arm}) * i_wz;
        n_kwb = $signed({1'b0, i_cfg.back_yaw_arm}) * i_wz;
    end

    // stage 2: signed Q26.8 sum, magnitude, cap
    always_comb begin
        logic signed [SUM_W-1:0] s;
        logic signed [KW_W-1:0]  kw;
        logic [EXT_W-1:0]        se, mag;
        for (int l = 0; l < LANES; l++) begin
            kw = (l < 2) ? r_kwf : r_kwb;
            s  = $signed({{(SUM_W-8-LIN_W){r_lin[l][LIN_W-1]}}, r_lin[l], 8'b0})
               + $signed({{(SUM_W-KW_W){kw[KW_W-1]}}, kw});
            se = {{(EXT_W-SUM_W){s[SUM_W-1]}}, s};
            n_neg2[l] = s[SUM_W-1];
            mag = n_neg2[l] ? (~se + EXT_W'(1)) : se;
            if (mag > MAG_CAP) begin
                mag = MAG_CAP;
            end
            n_mag2[l] = mag[MAG_W-1:0];
        end
    end

    // stage 3: gain, truncate, clamp
    always_comb begin
        logic [PROD_W-1:0] prod;
        logic [MAG_W-1:0]  q;
        for (int l = 0; l < LANES; l++) begin
            prod = PROD_W'(r_mag2[l]) * PROD_W'(i_cfg.wheel_gain);
            q    = prod[PROD_W-1:GAIN_W];
            n_mag3[l] = (q > MAG_W'(i_cfg.clamp_limit)) ? i_cfg.clamp_limit : q[CLAMP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lin  <= n_lin;
        r_kwf  <= n_kwf;
        r_kwb  <= n_kwb;
        r_mag2 <= n_mag2;
        r_neg2 <= n_neg2;
        r_mag3 <= n_mag3;
        r_neg3 <= r_neg2;
    end

    assign o_valid = r_v3;
    assign o_neg   = r_neg3;
    assign o_mag   = r_mag3;

endmodule

/* rtl/core/mdml_limit.sv */
// Total magnitude limiter: sum, scale multiply and pipelined restoring divide.
module mdml_limit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  logic [mdml_pkg::LANES-1:0]             i_neg,
    input  mdml_pkg::t_mag_vec                     i_mag,
    input  logic [mdml_pkg::TOT_W-1:0]             i_max_total,
    output logic                                   o_valid,
    output logic [mdml_pkg::LANES-1:0][mdml_pkg::WORD_W-1:0] o_wheel,
    output logic                                   o_flag
);
    import mdml_pkg::*;

    typedef logic [LANES-1:0][REM_W-1:0] t_rem_vec;
    typedef logic [LANES-1:0][Q_W-1:0]   t_low_vec;

    // sum stage
    logic             r_va, r_flag_a;
    logic [TOT_W-1:0] r_tot_a;
    logic [LANES-1:0] r_neg_a;
    t_mag_vec         r_mag_a;
    logic [TOT_W-1:0] n_tot;

    // divider stages, index 0 is the entry
    logic             r_v    [DIV_STAGES+1];
    logic             r_flag [DIV_STAGES+1];
    logic [TOT_W-1:0] r_tot  [DIV_STAGES];
    logic [LANES-1:0] r_neg  [DIV_STAGES+1];
    t_mag_vec         r_mag  [DIV_STAGES+1];
    t_rem_vec         r_rem  [DIV_STAGES];
    t_low_vec         r_low  [DIV_STAGES+1];

    t_rem_vec         n_rem0;
    t_low_vec         n_low0;
    t_rem_vec         n_rem  [DIV_STAGES];
    t_low_vec         n_low  [DIV_STAGES];

    logic                               r_vo, r_flag_o;
    logic [LANES-1:0][WORD_W-1:0]       r_wheel, n_wheel;

    always_comb begin
        n_tot = '0;
        for (int l = 0; l < LANES; l++) begin
            n_tot = n_tot + TOT_W'(i_mag[l]);
        end
    end

    // scale numerator, split into first partial remainder and pending bits
    always_comb begin
        logic [NUM_W-1:0] num;
        for (int l = 0; l < LANES; l++) begin
            num = NUM_W'(r_mag_a[l]) * NUM_W'(i_max_total);
            n_rem0[l] = num[NUM_W-1:Q_W];
            n_low0[l] = num[Q_W-1:0];
        end
    end

    // each stage retires DIV_BITS quotient bits
    always_comb begin
        logic [REM_W:0]   sh;
        logic [REM_W-1:0] rem;
        logic [Q_W-1:0]   low;
        for (int s = 0; s < DIV_STAGES; s++) begin
            for (int l = 0; l < LANES; l++) begin
                rem = r_rem[s][l];
                low = r_low[s][l];
                for (int b = 0; b < DIV_BITS; b++) begin
                    sh  = {rem, low[Q_W-1]};
                    low = {low[Q_W-2:0], 1'b0};
                    if (sh >= {1'b0, r_tot[s]}) begin
                        sh     = sh - {1'b0, r_tot[s]};
                        low[0] = 1'b1;
                    end
                    rem = sh[REM_W-1:0];
                end
                n_rem[s][l] = rem;
                n_low[s][l] = low;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            for (int s = 0; s <= DIV_STAGES; s++) begin
                r_v[s] <= 1'b0;
            end
        end else begin
            r_va   <= i_valid;
            r_v[0] <= r_va;
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_v[s+1] <= r_v[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tot_a   <= n_tot;
        r_flag_a  <= n_tot > i_max_total;
        r_neg_a   <= i_neg;
        r_mag_a   <= i_mag;
        r_flag[0] <= r_flag_a;
        r_tot[0]  <= r_tot_a;
        r_neg[0]  <= r_neg_a;
        r_mag[0]  <= r_mag_a;
        r_rem[0]  <= n_rem0;
        r_low[0]  <= n_low0;
        for (int s = 0; s < DIV_STAGES; s++) begin
            r_flag[s+1] <= r_flag[s];
            r_neg[s+1]  <= r_neg[s];
            r_mag[s+1]  <= r_mag[s];
            r_low[s+1]  <= n_low[s];
        end
        for (int s = 0; s < DIV_STAGES - 1; s++) begin
            r_tot[s+1] <= r_tot[s];
            r_rem[s+1] <= n_rem[s];
        end
    end

    // pick scaled or clamped magnitude, restore sign
    always_comb begin
        logic [WORD_W-1:0] val;
        for (int l = 0; l < LANES; l++) begin
            val = r_flag[DIV_STAGES] ? WORD_W'(r_low[DIV_STAGES][l])
                                     : WORD_W'(r_mag[DIV_STAGES][l]);
            n_wheel[l] = r_neg[DIV_STAGES][l] ? (~val + WORD_W'(1)) : val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else begin
            r_vo <= r_v[DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        r_wheel  <= n_wheel;
        r_flag_o <= r_flag[DIV_STAGES];
    end

    assign o_valid = r_vo;
    assign o_wheel = r_wheel;
    assign o_flag  = r_flag_o;

endmodule

/* dv/mecanum_drive_mixer_limiter_unit_test.sv */
// Self-checking testbench for the mecanum drive mixer and limiter unit.
module mecanum_drive_mixer_limiter_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mdml_pkg::*;

    typedef struct {
        logic signed [WORD_W-1:0] rf;
        logic signed [WORD_W-1:0] lf;
        logic signed [WORD_W-1:0] lb;
        logic signed [WORD_W-1:0] rb;
        logic                     limited;
    } t_wheel_set;

    class wheel_scoreboard;
        t_wheel_set pending[$];
        int         mismatches;
        logic [GAIN_W-1:0]  gain;
        logic [GAIN_W-1:0]  kf;
        logic [GAIN_W-1:0]  kb;
        logic [CLAMP_W-1:0] clamp;
        logic [TOT_W-1:0]   total_lim;

        function new();
            mismatches = 0;
            gain = 256;
            kf = 256;
            kb = 256;
            clamp = 16384;
            total_lim = 131072;
        endfunction

        function longint wheel_mix(longint lin, longint w, longint k);
            longint s;
            longint mag;
            longint q;
            s = lin * 256 + k * w;
            mag = (s < 0) ? -s : s;
            if (mag > (64'sd1 <<< 40)) mag = 64'sd1 <<< 40;
            q = (mag * longint'(gain)) >>> 16;
            if (q > longint'(clamp)) q = clamp;
            return (s < 0) ? -q : q;
        endfunction

        function void note_command(logic signed [COMMAND_WIDTH-1:0] vx,
                                   logic signed [COMMAND_WIDTH-1:0] vy,
                                   logic signed [COMMAND_WIDTH-1:0] wz);
            longint     w[4];
            longint     total;
            longint     m;
            t_wheel_set e;
            w[0] = wheel_mix(-longint'(vx) + vy, wz, kf);
            w[1] = wheel_mix(longint'(vx) + vy, wz, kf);
            w[2] = wheel_mix(longint'(vx) - vy, wz, kb);
            w[3] = wheel_mix(-longint'(vx) - vy, wz, kb);
            total = 0;
            foreach (w[i]) total += (w[i] < 0) ? -w[i] : w[i];
            e.limited = total > longint'(total_lim);
            if (e.limited) begin
                foreach (w[i]) begin
                    m = (w[i] < 0) ? -w[i] : w[i];
                    m = (m * longint'(total_lim)) / total;
                    w[i] = (w[i] < 0) ? -m : m;
                end
            end
            e.rf = w[0][15:0];
            e.lf = w[1][15:0];
            e.lb = w[2][15:0];
            e.rb = w[3][15:0];
            pending.push_back(e);
        endfunction

        function void check_wheels(t_wheel_set got);
            t_wheel_set e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("ERROR: unexpected beat rf=%0d", got.rf);
                return;
            end
            e = pending.pop_front();
            if (e.rf !== got.rf || e.lf !== got.lf || e.lb !== got.lb ||
                e.rb !== got.rb || e.limited !== got.limited) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: exp %0d %0d %0d %0d %0b got %0d %0d %0d %0d %0b",
                             e.rf, e.lf, e.lb, e.rb, e.limited,
                             got.rf, got.lf, got.lb, got.rb, got.limited);
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic start = 0;
    logic busy;
    logic signed [COMMAND_WIDTH-1:0] i_vx = 0, i_vy = 0, i_wz = 0;
    logic o_valid;
    logic signed [WORD_W-1:0] o_wheel_rf, o_wheel_lf, o_wheel_lb, o_wheel_rb;
    logic o_power_limited;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [ADDR_W-1:0] paddr = 0;
    logic [DATA_W-1:0] pwdata = 0;
    logic [DATA_W-1:0] prdata;
    logic pready;

    wheel_scoreboard sb;

    mecanum_drive_mixer_limiter_unit dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        t_wheel_set got;
        if (i_rst_n && o_valid) begin
            got.rf = o_wheel_rf;
            got.lf = o_wheel_lf;
            got.lb = o_wheel_lb;
            got.rb = o_wheel_rb;
            got.limited = o_power_limited;
            sb.check_wheels(got);
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [DATA_W-1:0] val);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= ADDR_W'(idx) << 2;
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        case (idx)
            REG_WHEEL_GAIN:    sb.gain = val[GAIN_W-1:0];
            REG_FRONT_YAW_ARM: sb.kf = val[GAIN_W-1:0];
            REG_BACK_YAW_ARM:  sb.kb = val[GAIN_W-1:0];
            REG_CLAMP_LIMIT:   sb.clamp = val[CLAMP_W-1:0];
            REG_TOTAL_LIMIT:   sb.total_lim = val[TOT_W-1:0];
            default: ;
        endcase
        // idle between transfers
        @(posedge i_clk);
    endtask

    task automatic send_command(logic [15:0] vx, logic [15:0] vy, logic [15:0] wz,
                                int gap);
        if (gap > 0) begin
            start <= 0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1;
        i_vx <= vx;
        i_vy <= vy;
        i_wz <= wz;
        do @(posedge i_clk); while (busy);
        sb.note_command(vx, vy, wz);
    endtask

    task automatic drain_results();
        start <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic set_all(logic [31:0] g, logic [31:0] f, logic [31:0] b,
                           logic [31:0] c, logic [31:0] t);
        write_reg(REG_WHEEL_GAIN, g);
        write_reg(REG_FRONT_YAW_ARM, f);
        write_reg(REG_BACK_YAW_ARM, b);
        write_reg(REG_CLAMP_LIMIT, c);
        write_reg(REG_TOTAL_LIMIT, t);
    endtask

    function automatic logic [15:0] pick_cmd();
        case ($urandom_range(0, 4))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($signed($urandom_range(0, 200)) - 100);
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [15:0] edges[6];
        int gap;
        sb = new();
        edges = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001, 16'h0100};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: field extremes at reset settings
        for (int i = 0; i < 6; i++)
            send_command(edges[i], edges[(i + 2) % 6], edges[(i + 4) % 6], 0);
        send_command(16'h0040, 16'h0030, 16'h0000, 1);
        send_command(16'h7fff, 16'h7fff, 16'h7fff, 0);
        send_command(16'h8000, 16'h8000, 16'h8000, 0);
        drain_results();
        // zero gain, zero clamp with tight total, unequal yaw arms, maximal registers
        set_all(0, 256, 256, 16384, 131072);
        send_command(16'h7fff, 16'h1234, 16'h8000, 0);
        drain_results();
        set_all(256, 256, 256, 0, 10);
        send_command(16'h7fff, 16'h1234, 16'h8000, 0);
        drain_results();
        set_all(256, 65535, 0, 100, 150);
        send_command(16'h0064, 16'h0032, 16'h0019, 0);
        send_command(16'h8000, 16'h7fff, 16'h7fff, 0);
        send_command(16'h0003, 16'hfffd, 16'h0001, 0);
        drain_results();
        set_all(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        send_command(16'h8000, 16'h8000, 16'h7fff, 0);
        send_command(16'h0001, 16'h0000, 16'hffff, 0);
        drain_results();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: set_all(256, 256, 256, 16384, 131072);
                1: set_all(65535, 65535, 65535, 32767, 0);
                7: set_all(0, 0, 0, 0, 0);
                default: set_all($urandom_range(0, 65535), $urandom_range(0, 65535),
                                 $urandom_range(0, 65535), $urandom_range(0, 32767),
                                 $urandom_range(0, 262143));
            endcase
            for (int n = 0; n < 80; n++) begin
                gap = (phase % 3 == 0) ? 0 : $urandom_range(0, 11);
                send_command(pick_cmd(), pick_cmd(), pick_cmd(), gap);
            end
            drain_results();
        end

        if (sb.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #2ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule
